// ===== rtl/core/ctrs_pkg.sv =====
// Shared types and constants for the color table ramp sequencer.
// No dependencies; compiled before the interfaces and the core.
`default_nettype none

package ctrs_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int PTR_W       = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [7:0] END_MARK = 8'd255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TICKS  = 3'd4;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_RAMP  = 3'b010,
        PH_BLANK = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_color;

    typedef struct packed {
        logic [7:0] step_size;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_entry;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] entry_index;
        logic [7:0]       target_red;
        logic [7:0]       target_green;
        logic [7:0]       target_blue;
        logic [7:0]       step_size;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       done_res;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/core/ctrs_in_if.sv =====
// Valid/ready channel carrying sequencer input beats (tick or table write).
// Depends on ctrs_pkg.
`default_nettype none

interface ctrs_in_if;
    logic                valid;
    logic                ready;
    ctrs_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ctrs_out_if.sv =====
// Valid/ready channel carrying sequencer result beats (shown color, done).
// Depends on ctrs_pkg.
`default_nettype none

interface ctrs_out_if;
    logic                valid;
    logic                ready;
    ctrs_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/color_table_ramp_sequencer_top.sv =====
// Color table ramp sequencer core: entry table memory, ramp state, output register.
// Depends on ctrs_pkg, ctrs_in_if and ctrs_out_if.
//
// Usage:
//   i_in carries one beat per item. mode 1 writes one table entry (target
//   color and step size) at entry_index; mode 0 is one timer tick that
//   advances the sequencer. Every accepted beat gives exactly one result
//   beat on o_out: the displayed color and done_res, which is 1 on the tick
//   that meets an entry whose red is 255.
//   A result is registered and valid the cycle after its input beat is accepted.
//   Throughput: one beat per cycle unless o_out stalls. The table is read ahead
//   at the next entry pointer, so a tick finds its entry already registered;
//   a table write to that same entry is forwarded into the read register.
//   The config port (i_cfg_wr_en, i_cfg_index, i_cfg_data) must be written only
//   while no beat is in flight; the block itself does not enforce this.
//   Reset clears the phase (idle), pointer, counters and both colors. The
//   table is not cleared: entries must be written before a tick reads them.
//   When o_out stalls, the result register holds and i_in.ready stays low
//   until the held beat is taken; a beat may enter in the cycle it drains.
`default_nettype none

module color_table_ramp_sequencer_top (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_wr_en,
    input  wire  [ctrs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [ctrs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    ctrs_in_if.sink                               i_in,
    ctrs_out_if.source                            o_out
);

    localparam logic [ctrs_pkg::PTR_W-1:0] PTR_LAST =
        ctrs_pkg::PTR_W'(ctrs_pkg::TABLE_DEPTH - 1);
    localparam logic [ctrs_pkg::IDX_W:0] DEPTH_LIM =
        (ctrs_pkg::IDX_W + 1)'(ctrs_pkg::TABLE_DEPTH);

    // configuration
    logic [7:0] r_start_red, r_start_green, r_start_blue;
    logic [7:0] r_blank_ticks, r_step_ticks;

    // sequencer state
    ctrs_pkg::t_phase                r_phase, n_phase;
    logic [ctrs_pkg::PTR_W-1:0]      r_ptr, n_ptr;
    logic [7:0]                      r_blank_cnt, n_blank_cnt;
    logic [7:0]                      r_step_cnt, n_step_cnt;
    ctrs_pkg::t_color                r_held, n_held;
    ctrs_pkg::t_color                r_shown, n_shown;

    // table memory and its registered read port
    ctrs_pkg::t_entry                r_mem [ctrs_pkg::TABLE_DEPTH];
    ctrs_pkg::t_entry                r_rd_entry;
    ctrs_pkg::t_entry                wr_entry;
    logic [ctrs_pkg::PTR_W-1:0]      wr_addr, rd_addr;
    logic                            wr_en;

    // output register
    logic                            r_out_valid;
    ctrs_pkg::t_out_item             r_out_data;

    logic                            in_acc;
    logic                            done_c;
    logic                            is_tick;
    ctrs_pkg::t_color                ramped;

    function automatic logic [7:0] ramp_ch(input logic [7:0] cur, input logic [7:0] tgt,
                                           input logic [7:0] step);
        logic [8:0] sum;
        logic [7:0] dif;
        logic [7:0] res;
        sum = {1'b0, cur} + {1'b0, step};
        dif = (cur >= step) ? (cur - step) : 8'd0;
        res = cur;
        if (cur < tgt) begin
            res = (sum > {1'b0, tgt}) ? tgt : sum[7:0];
        end else if (cur > tgt) begin
            res = (dif < tgt) ? tgt : dif;
        end
        return res;
    endfunction

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;
    assign is_tick    = in_acc && (i_in.data.mode == ctrs_pkg::MODE_TICK);

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // table write port
    assign wr_en = in_acc && (i_in.data.mode == ctrs_pkg::MODE_WRITE)
                   && ({1'b0, i_in.data.entry_index} < DEPTH_LIM);
    assign wr_addr = i_in.data.entry_index[ctrs_pkg::PTR_W-1:0];
    assign wr_entry = '{step_size: i_in.data.step_size, blue: i_in.data.target_blue,
                        green: i_in.data.target_green, red: i_in.data.target_red};

    assign ramped.red   = ramp_ch(r_held.red,   r_rd_entry.red,   r_rd_entry.step_size);
    assign ramped.green = ramp_ch(r_held.green, r_rd_entry.green, r_rd_entry.step_size);
    assign ramped.blue  = ramp_ch(r_held.blue,  r_rd_entry.blue,  r_rd_entry.step_size);

    always_comb begin
        n_phase     = r_phase;
        n_ptr       = r_ptr;
        n_blank_cnt = r_blank_cnt;
        n_step_cnt  = r_step_cnt;
        n_held      = r_held;
        n_shown     = r_shown;
        done_c      = 1'b0;
        if (is_tick) begin
            case (r_phase)
                ctrs_pkg::PH_RAMP: begin
                    if (r_rd_entry.red == ctrs_pkg::END_MARK) begin
                        n_ptr       = '0;
                        n_blank_cnt = 8'd0;
                        n_step_cnt  = 8'd0;
                        n_phase     = ctrs_pkg::PH_IDLE;
                        done_c      = 1'b1;
                    end else if (r_step_cnt != 8'd0) begin
                        n_shown    = r_held;
                        n_step_cnt = r_step_cnt - 8'd1;
                        // waiting between steps runs the blanking action too
                        if (r_blank_cnt != 8'd0) begin
                            n_shown     = '0;
                            n_blank_cnt = r_blank_cnt - 8'd1;
                        end else begin
                            n_blank_cnt = r_blank_ticks;
                            n_phase     = ctrs_pkg::PH_RAMP;
                        end
                    end else begin
                        n_step_cnt = r_step_ticks;
                        n_held     = ramped;
                        n_shown    = ramped;
                        if (ramped.red == r_rd_entry.red && ramped.green == r_rd_entry.green
                            && ramped.blue == r_rd_entry.blue) begin
                            n_ptr = (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
                        end
                        n_phase = ctrs_pkg::PH_BLANK;
                    end
                end
                ctrs_pkg::PH_BLANK: begin
                    if (r_blank_cnt != 8'd0) begin
                        n_shown     = '0;
                        n_blank_cnt = r_blank_cnt - 8'd1;
                    end else begin
                        n_blank_cnt = r_blank_ticks;
                        n_phase     = ctrs_pkg::PH_RAMP;
                    end
                end
                default: begin
                    n_phase     = ctrs_pkg::PH_RAMP;
                    n_ptr       = '0;
                    n_blank_cnt = r_blank_ticks;
                    n_step_cnt  = r_step_ticks;
                    n_held      = '{blue: r_start_blue, green: r_start_green, red: r_start_red};
                end
            endcase
        end
    end

    // prefetch the entry at the next pointer
    assign rd_addr = i_rst_n ? n_ptr : '0;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_entry;
        end
        // forward a write to the entry being fetched
        if (wr_en && (wr_addr == rd_addr)) begin
            r_rd_entry <= wr_entry;
        end else begin
            r_rd_entry <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_red   <= 8'd0;
            r_start_green <= 8'd0;
            r_start_blue  <= 8'd0;
            r_blank_ticks <= 8'd0;
            r_step_ticks  <= 8'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ctrs_pkg::CFG_START_RED:   r_start_red   <= i_cfg_data;
                ctrs_pkg::CFG_START_GREEN: r_start_green <= i_cfg_data;
                ctrs_pkg::CFG_START_BLUE:  r_start_blue  <= i_cfg_data;
                ctrs_pkg::CFG_BLANK_TICKS: r_blank_ticks <= i_cfg_data;
                ctrs_pkg::CFG_STEP_TICKS:  r_step_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ctrs_pkg::PH_IDLE;
            r_ptr       <= '0;
            r_blank_cnt <= 8'd0;
            r_step_cnt  <= 8'd0;
            r_held      <= '0;
            r_shown     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_ptr       <= n_ptr;
            r_blank_cnt <= n_blank_cnt;
            r_step_cnt  <= n_step_cnt;
            r_held      <= n_held;
            r_shown     <= n_shown;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_data <= '{red: n_shown.red, green: n_shown.green, blue: n_shown.blue,
                            done_res: done_c};
        end
    end

    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_tick && done_c) |=> (r_phase == ctrs_pkg::PH_IDLE && r_ptr == '0))
        else $error("end marker did not return the sequencer to idle");

    a_idle_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ctrs_pkg::PH_IDLE) |-> (r_ptr == '0 && r_blank_cnt == 8'd0
                                              && r_step_cnt == 8'd0))
        else $error("idle phase with pointer or counters not cleared");

    a_ptr_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !is_tick |=> $stable(r_ptr))
        else $error("entry pointer moved without a tick");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_out_valid && r_out_data.done_res == $past(done_c)))
        else $error("accepted beat did not produce its result");

endmodule

`default_nettype wire
